// File: rtl/core/gfw_pkg.sv
// ----------------------------------------------------------------------------
// gfw_pkg: shared types and constants of the glyph to framebuffer writer
// Request and register codes, configuration view, queued item and pixel
// operation formats used between the front end, queue, sequencer and
// pixel pipeline.
// ----------------------------------------------------------------------------
package gfw_pkg;

  // Frame and glyph geometry
  localparam int unsigned MAX_DIM      = 4096;
  localparam int unsigned GLYPH_SIZE   = 8;
  localparam int unsigned GLYPH_W      = 3;
  localparam int unsigned GLYPH_PIXELS = GLYPH_SIZE * GLYPH_SIZE;
  localparam int unsigned GCNT_W       = 2 * GLYPH_W;

  // Field widths
  localparam int unsigned POS_W    = 12;
  localparam int unsigned COORD_W  = POS_W + GLYPH_W;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned BPP_W    = 3;
  localparam int unsigned LAYOUT_W = 9;
  localparam int unsigned OFS_W    = 26;
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned COL_W    = 8;
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned COL_FULL = 255;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Item queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_BYTES_PP     = 3'd2,
    CFG_RED_LAYOUT   = 3'd3,
    CFG_GREEN_LAYOUT = 3'd4,
    CFG_BLUE_LAYOUT  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_GLYPH  = 2'd1,
    REQ_DECODE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_GLYPH
  } seq_state_t;

  typedef struct packed {
    logic [DIM_W-1:0]                     frame_width;
    logic [DIM_W-1:0]                     frame_height;
    logic [BPP_W-1:0]                     bytes_per_pixel;
    logic [NUM_CH-1:0][LAYOUT_W-1:0]      layout;
  } cfg_t;

  typedef struct packed {
    req_t                           req;
    logic [POS_W-1:0]               pos_x;
    logic [POS_W-1:0]               pos_y;
    logic [GLYPH_PIXELS-1:0]        glyph_bits;
    logic [NUM_CH-1:0][COL_W-1:0]   fg;
    logic [NUM_CH-1:0][COL_W-1:0]   bg;
    logic [PIX_W-1:0]               raw;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic                           valid;
    logic                           decode;
    logic                           last;
    logic [COORD_W-1:0]             x;
    logic [COORD_W-1:0]             y;
    logic [NUM_CH-1:0][COL_W-1:0]   rgb;
    logic [PIX_W-1:0]               raw;
  } pix_op_t;

  // Expand one glyph bit into a pixel write: column mirrored within the cell
  function automatic pix_op_t glyph_op(input item_t it, input logic [GCNT_W-1:0] k);
    pix_op_t op;
    op        = '0;
    op.valid  = 1'b1;
    op.decode = 1'b0;
    op.last   = (k == GCNT_W'(GLYPH_PIXELS - 1));
    op.x      = {it.pos_x, ~k[GLYPH_W-1:0]};
    op.y      = {it.pos_y, k[GCNT_W-1:GLYPH_W]};
    op.rgb    = it.glyph_bits[k] ? it.fg : it.bg;
    op.raw    = '0;
    return op;
  endfunction

endpackage

// File: rtl/core/gfw_front.sv
// ----------------------------------------------------------------------------
// gfw_front: request intake and configuration registers
// Accepts items on start, drops unused request codes and pushes the rest
// into the item queue. Holds the frame geometry and channel layouts.
// ----------------------------------------------------------------------------
module gfw_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_req_type,
  input  logic [gfw_pkg::POS_W-1:0]              in_pos_x,
  input  logic [gfw_pkg::POS_W-1:0]              in_pos_y,
  input  logic [gfw_pkg::GLYPH_PIXELS-1:0]       in_glyph_bits,
  input  logic [gfw_pkg::COL_W-1:0]              in_fg_red,
  input  logic [gfw_pkg::COL_W-1:0]              in_fg_green,
  input  logic [gfw_pkg::COL_W-1:0]              in_fg_blue,
  input  logic [gfw_pkg::COL_W-1:0]              in_bg_red,
  input  logic [gfw_pkg::COL_W-1:0]              in_bg_green,
  input  logic [gfw_pkg::COL_W-1:0]              in_bg_blue,
  input  logic [gfw_pkg::PIX_W-1:0]              in_raw_pixel,
  input  logic                                   cfg_we,
  input  logic [gfw_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [gfw_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  gfw_pkg::q_stat_t                       q_stat,
  output logic                                   push,
  output gfw_pkg::item_t                         push_item,
  output gfw_pkg::cfg_t                          cfg
);

  gfw_pkg::cfg_t cfg_r;
  gfw_pkg::cfg_t cfg_nxt;

  // Hold off new items while the queue is full
  assign busy = q_stat.full;

  // Classify: unused request codes are accepted and dropped
  assign push = start && !busy && (gfw_pkg::req_t'(in_req_type) != gfw_pkg::REQ_NONE);

  always_comb begin
    push_item                             = '0;
    push_item.req                         = gfw_pkg::req_t'(in_req_type);
    push_item.pos_x                       = in_pos_x;
    push_item.pos_y                       = in_pos_y;
    push_item.glyph_bits                  = in_glyph_bits;
    push_item.fg[gfw_pkg::CH_RED]         = in_fg_red;
    push_item.fg[gfw_pkg::CH_GREEN]       = in_fg_green;
    push_item.fg[gfw_pkg::CH_BLUE]        = in_fg_blue;
    push_item.bg[gfw_pkg::CH_RED]         = in_bg_red;
    push_item.bg[gfw_pkg::CH_GREEN]       = in_bg_green;
    push_item.bg[gfw_pkg::CH_BLUE]        = in_bg_blue;
    push_item.raw                         = in_raw_pixel;
  end

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (gfw_pkg::cfg_idx_t'(cfg_index))
        gfw_pkg::CFG_FRAME_WIDTH:  cfg_nxt.frame_width = cfg_data[gfw_pkg::DIM_W-1:0];
        gfw_pkg::CFG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_data[gfw_pkg::DIM_W-1:0];
        gfw_pkg::CFG_BYTES_PP:     cfg_nxt.bytes_per_pixel = cfg_data[gfw_pkg::BPP_W-1:0];
        gfw_pkg::CFG_RED_LAYOUT:
          cfg_nxt.layout[gfw_pkg::CH_RED] = cfg_data[gfw_pkg::LAYOUT_W-1:0];
        gfw_pkg::CFG_GREEN_LAYOUT:
          cfg_nxt.layout[gfw_pkg::CH_GREEN] = cfg_data[gfw_pkg::LAYOUT_W-1:0];
        gfw_pkg::CFG_BLUE_LAYOUT:
          cfg_nxt.layout[gfw_pkg::CH_BLUE] = cfg_data[gfw_pkg::LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width                 <= 13'd640;
      cfg_r.frame_height                <= 13'd480;
      cfg_r.bytes_per_pixel             <= 3'd4;
      cfg_r.layout[gfw_pkg::CH_RED]     <= 9'd391;
      cfg_r.layout[gfw_pkg::CH_GREEN]   <= 9'd135;
      cfg_r.layout[gfw_pkg::CH_BLUE]    <= 9'd7;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/gfw_queue.sv
// ----------------------------------------------------------------------------
// gfw_queue: item queue between intake and sequencer
// Small register FIFO; the head entry is always visible to the reader.
// ----------------------------------------------------------------------------
module gfw_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  gfw_pkg::item_t       push_item,
  input  logic                 pop,
  output gfw_pkg::item_t       head,
  output gfw_pkg::q_stat_t     q_stat
);

  gfw_pkg::item_t                   mem_r [gfw_pkg::QUEUE_DEPTH];
  logic [gfw_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [gfw_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [gfw_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store item payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == gfw_pkg::QCNT_W'(gfw_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

// File: rtl/core/gfw_seq.sv
// ----------------------------------------------------------------------------
// gfw_seq: request sequencer
// Pops queued items and issues one pixel operation per cycle unless idle
// with the queue empty; a glyph becomes 64 pixel writes, row by row.
// ----------------------------------------------------------------------------
module gfw_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gfw_pkg::item_t       head,
  input  gfw_pkg::q_stat_t     q_stat,
  output logic                 pop,
  output gfw_pkg::pix_op_t     op
);

  gfw_pkg::seq_state_t              state_r, state_nxt;
  logic [gfw_pkg::GCNT_W-1:0]       cnt_r, cnt_nxt;
  gfw_pkg::item_t                   gly_r, gly_nxt;
  gfw_pkg::pix_op_t                 op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfw_pkg::SEQ_IDLE;
      cnt_r   <= '0;
      op_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
    end
  end

  // Hold the glyph being expanded
  always_ff @(posedge clk) begin
    gly_r <= gly_nxt;
  end

  // Pop the head item or advance through the glyph
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    gly_nxt   = gly_r;
    pop       = 1'b0;
    op_nxt    = '0;
    unique case (state_r)
      gfw_pkg::SEQ_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          unique case (head.req)
            gfw_pkg::REQ_WRITE: begin
              op_nxt.valid = 1'b1;
              op_nxt.last  = 1'b1;
              op_nxt.x     = gfw_pkg::COORD_W'(head.pos_x);
              op_nxt.y     = gfw_pkg::COORD_W'(head.pos_y);
              op_nxt.rgb   = head.fg;
            end
            gfw_pkg::REQ_DECODE: begin
              op_nxt.valid  = 1'b1;
              op_nxt.decode = 1'b1;
              op_nxt.last   = 1'b1;
              op_nxt.raw    = head.raw;
            end
            gfw_pkg::REQ_GLYPH: begin
              op_nxt    = gfw_pkg::glyph_op(head, '0);
              gly_nxt   = head;
              cnt_nxt   = gfw_pkg::GCNT_W'(1);
              state_nxt = gfw_pkg::SEQ_GLYPH;
            end
            default: ;
          endcase
        end
      end
      gfw_pkg::SEQ_GLYPH: begin
        op_nxt  = gfw_pkg::glyph_op(gly_r, cnt_r);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == gfw_pkg::GCNT_W'(gfw_pkg::GLYPH_PIXELS - 1)) begin
          state_nxt = gfw_pkg::SEQ_IDLE;
        end
      end
      default: state_nxt = gfw_pkg::SEQ_IDLE;
    endcase
  end

  assign op = op_r;

endmodule

// File: rtl/core/gfw_pix.sv
// ----------------------------------------------------------------------------
// gfw_pix: pixel arithmetic pipeline
// Four stages: scale numerators and row product, quotient estimate and
// linear address, quotient correction and byte offset, channel placement.
// ----------------------------------------------------------------------------
module gfw_pix (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gfw_pkg::pix_op_t                    op,
  input  gfw_pkg::cfg_t                       cfg,
  output logic                                out_strobe,
  output logic                                out_write_enable,
  output logic [gfw_pkg::OFS_W-1:0]           out_byte_offset,
  output logic [gfw_pkg::PIX_W-1:0]           out_packed_pixel,
  output logic [gfw_pkg::COL_W-1:0]           out_red,
  output logic [gfw_pkg::COL_W-1:0]           out_green,
  output logic [gfw_pkg::COL_W-1:0]           out_blue,
  output logic                                out_last
);

  localparam int unsigned NUM_W  = 24;
  localparam int unsigned CVAL_W = 16;
  localparam int unsigned SIZE_W = 5;
  localparam int unsigned REC_W  = 32;
  localparam int unsigned PROD_W = NUM_W + REC_W;
  localparam int unsigned YW_W   = gfw_pkg::COORD_W + gfw_pkg::DIM_W;

  // Floor of (2^32-1)/(2^size-1), indexed by size minus one
  function automatic logic [REC_W-1:0] recip(input logic [3:0] size_m1);
    logic [REC_W-1:0] r;
    case (size_m1)
      4'd0:    r = 32'hFFFF_FFFF;
      4'd1:    r = 32'h5555_5555;
      4'd2:    r = 32'h2492_4924;
      4'd3:    r = 32'h1111_1111;
      4'd4:    r = 32'h0842_1084;
      4'd5:    r = 32'h0410_4104;
      4'd6:    r = 32'h0204_0810;
      4'd7:    r = 32'h0101_0101;
      4'd8:    r = 32'h0080_4020;
      4'd9:    r = 32'h0040_1004;
      4'd10:   r = 32'h0020_0400;
      4'd11:   r = 32'h0010_0100;
      4'd12:   r = 32'h0008_0040;
      4'd13:   r = 32'h0004_0010;
      4'd14:   r = 32'h0002_0004;
      default: r = 32'h0001_0001;
    endcase
    return r;
  endfunction

  // Channel layout fields
  logic [gfw_pkg::NUM_CH-1:0][SIZE_W-1:0]  ch_size;
  logic [gfw_pkg::NUM_CH-1:0][CVAL_W-1:0]  ch_max;
  logic [gfw_pkg::NUM_CH-1:0][4:0]         ch_shift;

  always_comb begin
    for (int ch = 0; ch < gfw_pkg::NUM_CH; ch++) begin
      ch_size[ch]  = SIZE_W'({1'b0, cfg.layout[ch][3:0]}) + SIZE_W'(1);
      ch_max[ch]   = CVAL_W'((17'd1 << ch_size[ch]) - 17'd1);
      ch_shift[ch] = cfg.layout[ch][8:4];
    end
  end

  // Stage 1: numerators, bounds check and row product
  logic                                    s1_valid_r;
  logic                                    s1_decode_r, s1_last_r, s1_inside_r;
  logic [gfw_pkg::COORD_W-1:0]             s1_x_r;
  logic [gfw_pkg::OFS_W-1:0]               s1_yw_r;
  logic [gfw_pkg::NUM_CH-1:0][NUM_W-1:0]   s1_num_r;
  logic [gfw_pkg::NUM_CH-1:0][NUM_W-1:0]   s1_num_nxt;
  logic [gfw_pkg::NUM_CH-1:0][CVAL_W-1:0]  dec_c;
  logic [YW_W-1:0]                         yw_full;
  logic                                    in_frame;

  always_comb begin
    for (int ch = 0; ch < gfw_pkg::NUM_CH; ch++) begin
      dec_c[ch] = CVAL_W'(op.raw >> ch_shift[ch]) & ch_max[ch];
      if (op.decode) begin
        s1_num_nxt[ch] = (NUM_W'(dec_c[ch]) << 8) - NUM_W'(dec_c[ch]);
      end else begin
        s1_num_nxt[ch] = (NUM_W'(op.rgb[ch]) << ch_size[ch]) - NUM_W'(op.rgb[ch]);
      end
    end
    yw_full  = op.y * cfg.frame_width;
    in_frame = (op.x < gfw_pkg::COORD_W'(cfg.frame_width)) &&
               (op.y < gfw_pkg::COORD_W'(cfg.frame_height)) &&
               (32'(op.x) < gfw_pkg::MAX_DIM) && (32'(op.y) < gfw_pkg::MAX_DIM);
  end

  always_ff @(posedge clk) begin
    s1_decode_r <= op.decode;
    s1_last_r   <= op.last;
    s1_inside_r <= in_frame;
    s1_x_r      <= op.x;
    s1_yw_r     <= yw_full[gfw_pkg::OFS_W-1:0];
    s1_num_r    <= s1_num_nxt;
  end

  // Stage 2: quotient estimates and linear pixel index
  logic                                    s2_valid_r;
  logic                                    s2_decode_r, s2_last_r, s2_inside_r;
  logic [gfw_pkg::OFS_W-1:0]               s2_lin_r;
  logic [gfw_pkg::NUM_CH-1:0][NUM_W-1:0]   s2_num_r;
  logic [gfw_pkg::NUM_CH-1:0][CVAL_W-1:0]  s2_q_r;
  logic [gfw_pkg::NUM_CH-1:0][CVAL_W-1:0]  s2_q_nxt;
  logic [gfw_pkg::NUM_CH-1:0][NUM_W:0]     est_w;
  logic [gfw_pkg::NUM_CH-1:0][PROD_W-1:0]  prod_d;

  always_comb begin
    for (int ch = 0; ch < gfw_pkg::NUM_CH; ch++) begin
      // n/255 from below: n/256 * (1 + 1/256 + 1/65536), at most one short
      est_w[ch]  = (NUM_W+1)'(s1_num_r[ch]) + (NUM_W+1)'(s1_num_r[ch] >> 8) +
                   (NUM_W+1)'(s1_num_r[ch] >> 16);
      // n/max through the reciprocal, at most one short
      prod_d[ch] = PROD_W'(s1_num_r[ch]) * PROD_W'(recip(cfg.layout[ch][3:0]));
      s2_q_nxt[ch] = s1_decode_r ? CVAL_W'(prod_d[ch] >> REC_W) : CVAL_W'(est_w[ch] >> 8);
    end
  end

  always_ff @(posedge clk) begin
    s2_decode_r <= s1_decode_r;
    s2_last_r   <= s1_last_r;
    s2_inside_r <= s1_inside_r;
    s2_lin_r    <= s1_yw_r + gfw_pkg::OFS_W'(s1_x_r);
    s2_num_r    <= s1_num_r;
    s2_q_r      <= s2_q_nxt;
  end

  // Stage 3: correct quotients by one, scale index to bytes
  logic                                    s3_valid_r;
  logic                                    s3_decode_r, s3_last_r, s3_inside_r;
  logic [gfw_pkg::OFS_W-1:0]               s3_ofs_r;
  logic [gfw_pkg::NUM_CH-1:0][CVAL_W-1:0]  s3_c_r;
  logic [gfw_pkg::NUM_CH-1:0][CVAL_W-1:0]  s3_c_nxt;
  logic [gfw_pkg::NUM_CH-1:0][NUM_W-1:0]   rem_w;
  logic [gfw_pkg::NUM_CH-1:0][NUM_W:0]     qm_d;
  logic [gfw_pkg::NUM_CH-1:0][NUM_W:0]     rem_d;
  logic [gfw_pkg::OFS_W+gfw_pkg::BPP_W-1:0] ofs_full;

  always_comb begin
    for (int ch = 0; ch < gfw_pkg::NUM_CH; ch++) begin
      rem_w[ch] = s2_num_r[ch] -
                  ((NUM_W'(s2_q_r[ch]) << 8) - NUM_W'(s2_q_r[ch]));
      qm_d[ch]  = ((NUM_W+1)'(s2_q_r[ch]) << ch_size[ch]) - (NUM_W+1)'(s2_q_r[ch]);
      rem_d[ch] = (NUM_W+1)'(s2_num_r[ch]) - qm_d[ch];
      if (s2_decode_r) begin
        s3_c_nxt[ch] = (rem_d[ch] >= (NUM_W+1)'(ch_max[ch])) ? s2_q_r[ch] + 1'b1 : s2_q_r[ch];
      end else begin
        s3_c_nxt[ch] = (rem_w[ch] >= NUM_W'(gfw_pkg::COL_FULL)) ?
                       s2_q_r[ch] + 1'b1 : s2_q_r[ch];
      end
    end
    ofs_full = s2_lin_r * cfg.bytes_per_pixel;
  end

  always_ff @(posedge clk) begin
    s3_decode_r <= s2_decode_r;
    s3_last_r   <= s2_last_r;
    s3_inside_r <= s2_inside_r;
    s3_ofs_r    <= ofs_full[gfw_pkg::OFS_W-1:0];
    s3_c_r      <= s3_c_nxt;
  end

  // Stage 4: place channels and drive result registers
  logic                                    we_r, last_r, strobe_r;
  logic [gfw_pkg::OFS_W-1:0]               ofs_r;
  logic [gfw_pkg::PIX_W-1:0]               pix_r, pix_nxt;
  logic [gfw_pkg::NUM_CH-1:0][gfw_pkg::COL_W-1:0] rgb_r, rgb_nxt;

  always_comb begin
    pix_nxt = '0;
    rgb_nxt = '0;
    for (int ch = 0; ch < gfw_pkg::NUM_CH; ch++) begin
      pix_nxt     = pix_nxt | (gfw_pkg::PIX_W'(s3_c_r[ch]) << ch_shift[ch]);
      rgb_nxt[ch] = s3_c_r[ch][gfw_pkg::COL_W-1:0];
    end
    if (s3_decode_r) begin
      pix_nxt = '0;
    end else begin
      rgb_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    we_r   <= s3_inside_r && !s3_decode_r;
    ofs_r  <= s3_decode_r ? '0 : s3_ofs_r;
    pix_r  <= pix_nxt;
    rgb_r  <= rgb_nxt;
    last_r <= s3_last_r;
  end

  // Advance stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      s1_valid_r <= op.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      strobe_r   <= s3_valid_r;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_write_enable = we_r;
  assign out_byte_offset  = ofs_r;
  assign out_packed_pixel = pix_r;
  assign out_red          = rgb_r[gfw_pkg::CH_RED];
  assign out_green        = rgb_r[gfw_pkg::CH_GREEN];
  assign out_blue         = rgb_r[gfw_pkg::CH_BLUE];
  assign out_last         = last_r;

endmodule

// File: rtl/core/glyph_to_framebuffer_writer.sv
// Path: an item goes from the queue through the sequencer op register, stages s1
// to s3 and output registers; a glyph gives 64 strobes on consecutive cycles.
// Throughput: one pixel write or decode per cycle, set by the sequencer issuing one
// pixel operation per cycle unless idle with the queue empty; during a glyph's 64
// writes the 4-entry item queue keeps accepting, busy rising when it is full.
// Reset (synchronous, rst_n low): registers to defaults, queue empty, pipeline idle.
// ----------------------------------------------------------------------------
// glyph_to_framebuffer_writer: framebuffer pixel engine
// Packs colours into pixel words with byte offsets and bounds checks,
// expands 8x8 glyphs into pixel writes and unpacks raw pixel words.
// ----------------------------------------------------------------------------
module glyph_to_framebuffer_writer (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_req_type,
  input  logic [gfw_pkg::POS_W-1:0]              in_pos_x,
  input  logic [gfw_pkg::POS_W-1:0]              in_pos_y,
  input  logic [gfw_pkg::GLYPH_PIXELS-1:0]       in_glyph_bits,
  input  logic [gfw_pkg::COL_W-1:0]              in_fg_red,
  input  logic [gfw_pkg::COL_W-1:0]              in_fg_green,
  input  logic [gfw_pkg::COL_W-1:0]              in_fg_blue,
  input  logic [gfw_pkg::COL_W-1:0]              in_bg_red,
  input  logic [gfw_pkg::COL_W-1:0]              in_bg_green,
  input  logic [gfw_pkg::COL_W-1:0]              in_bg_blue,
  input  logic [gfw_pkg::PIX_W-1:0]              in_raw_pixel,
  input  logic                                   cfg_we,
  input  logic [gfw_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [gfw_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic                                   out_strobe,
  output logic                                   out_write_enable,
  output logic [gfw_pkg::OFS_W-1:0]              out_byte_offset,
  output logic [gfw_pkg::PIX_W-1:0]              out_packed_pixel,
  output logic [gfw_pkg::COL_W-1:0]              out_red,
  output logic [gfw_pkg::COL_W-1:0]              out_green,
  output logic [gfw_pkg::COL_W-1:0]              out_blue,
  output logic                                   out_last
);

  logic                 push;
  logic                 pop;
  gfw_pkg::item_t       push_item;
  gfw_pkg::item_t       head;
  gfw_pkg::q_stat_t     q_stat;
  gfw_pkg::cfg_t        cfg;
  gfw_pkg::pix_op_t     op;

  gfw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_glyph_bits (in_glyph_bits),
    .in_fg_red     (in_fg_red),
    .in_fg_green   (in_fg_green),
    .in_fg_blue    (in_fg_blue),
    .in_bg_red     (in_bg_red),
    .in_bg_green   (in_bg_green),
    .in_bg_blue    (in_bg_blue),
    .in_raw_pixel  (in_raw_pixel),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item),
    .cfg           (cfg)
  );

  gfw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  gfw_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .op     (op)
  );

  gfw_pix u_pix (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .cfg              (cfg),
    .out_strobe       (out_strobe),
    .out_write_enable (out_write_enable),
    .out_byte_offset  (out_byte_offset),
    .out_packed_pixel (out_packed_pixel),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // Never push into a full queue or pop an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push) else $error("item pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop) else $error("item popped from empty queue");

  // A run that has not ended continues on the next cycle
  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> out_strobe) else $error("glyph run broken");

  // Decoded colours never come with a pixel store
  a_decode_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_red != 8'd0 || out_green != 8'd0 || out_blue != 8'd0))
    |-> (!out_write_enable && out_packed_pixel == '0))
    else $error("decode result carries a store");
`endif

endmodule

// File: tb/glyph_to_framebuffer_writer_tb.sv
// ----------------------------------------------------------------------------
// glyph_to_framebuffer_writer_tb: self-checking bench of the pixel engine
// Drives pixel writes, glyph draws, decodes and unused requests under a
// series of frame geometries and channel layouts, predicts every pixel
// result in a scoreboard and compares the result stream field by field.
// ----------------------------------------------------------------------------
module glyph_to_framebuffer_writer_tb;
  import gfw_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 30;

  // One request as presented on the input ports
  typedef struct {
    req_t        kind;
    bit [11:0]   x;
    bit [11:0]   y;
    bit [63:0]   glyph;
    bit [7:0]    fg_red, fg_green, fg_blue;
    bit [7:0]    bg_red, bg_green, bg_blue;
    bit [31:0]   raw;
  } pixel_request_t;

  // One result as seen on the output ports
  typedef struct packed {
    bit          write_enable;
    bit [25:0]   byte_offset;
    bit [31:0]   packed_pixel;
    bit [7:0]    red;
    bit [7:0]    green;
    bit [7:0]    blue;
    bit          last;
  } pixel_result_t;

  // Frame geometry and channel layouts written in one phase
  typedef struct {
    bit [12:0]   width;
    bit [12:0]   height;
    bit [2:0]    bpp;
    bit [8:0]    red_layout;
    bit [8:0]    green_layout;
    bit [8:0]    blue_layout;
  } frame_setup_t;

  // Pixel predictor and store of pending results
  class pixel_scoreboard;
    bit [12:0]       width, height;
    bit [2:0]        bpp;
    bit [8:0]        red_layout, green_layout, blue_layout;
    pixel_result_t   results_q[$];
    int unsigned     errors;

    function new();
      width        = 13'd640;
      height       = 13'd480;
      bpp          = 3'd4;
      red_layout   = 9'd391;
      green_layout = 9'd135;
      blue_layout  = 9'd7;
      errors       = 0;
    endfunction

    function int unsigned pending();
      return results_q.size();
    endfunction

    // Mirror a register write, keeping only the register's own width
    function void write_reg(cfg_idx_t idx, bit [12:0] data);
      case (idx)
        CFG_FRAME_WIDTH:  width        = data;
        CFG_FRAME_HEIGHT: height       = data;
        CFG_BYTES_PP:     bpp          = data[2:0];
        CFG_RED_LAYOUT:   red_layout   = data[8:0];
        CFG_GREEN_LAYOUT: green_layout = data[8:0];
        CFG_BLUE_LAYOUT:  blue_layout  = data[8:0];
        default: ;
      endcase
    endfunction

    // Scale an 8-bit level to the channel size and place it at its shift
    function bit [31:0] pack_channel(bit [8:0] lay, bit [7:0] level);
      longint unsigned top, c;
      top = (64'd1 << (lay[3:0] + 5'd1)) - 64'd1;
      c   = (64'(level) * top / 64'd255) & top;
      return 32'(c << lay[8:4]);
    endfunction

    // Extract a channel from a raw word and scale it back to 8 bits
    function bit [7:0] unpack_channel(bit [8:0] lay, bit [31:0] raw);
      longint unsigned top, c;
      top = (64'd1 << (lay[3:0] + 5'd1)) - 64'd1;
      c   = (64'(raw) >> lay[8:4]) & top;
      return 8'(c * 64'd255 / top);
    endfunction

    function void queue_pixel(longint unsigned x, longint unsigned y,
                              bit [7:0] r, bit [7:0] g, bit [7:0] b, bit last);
      pixel_result_t res;
      res              = '0;
      res.write_enable = (x < width) && (y < height) && (x < MAX_DIM) && (y < MAX_DIM);
      res.byte_offset  = 26'((y * width + x) * bpp);
      res.packed_pixel = pack_channel(red_layout, r) | pack_channel(green_layout, g) |
                         pack_channel(blue_layout, b);
      res.last         = last;
      results_q.push_back(res);
    endfunction

    // Work out every result that an accepted item causes
    function void note_request(pixel_request_t rq);
      pixel_result_t res;
      bit on;
      case (rq.kind)
        REQ_WRITE: begin
          queue_pixel(rq.x, rq.y, rq.fg_red, rq.fg_green, rq.fg_blue, 1'b1);
        end
        REQ_GLYPH: begin
          // Rows top to bottom; column mirrored within the cell
          for (int i = 0; i < GLYPH_SIZE; i++) begin
            for (int j = 0; j < GLYPH_SIZE; j++) begin
              on = rq.glyph[i * GLYPH_SIZE + j];
              queue_pixel(64'(rq.x) * GLYPH_SIZE + (GLYPH_SIZE - 1 - j),
                          64'(rq.y) * GLYPH_SIZE + i,
                          on ? rq.fg_red : rq.bg_red,
                          on ? rq.fg_green : rq.bg_green,
                          on ? rq.fg_blue : rq.bg_blue,
                          (i == GLYPH_SIZE - 1) && (j == GLYPH_SIZE - 1));
            end
          end
        end
        REQ_DECODE: begin
          res       = '0;
          res.red   = unpack_channel(red_layout, rq.raw);
          res.green = unpack_channel(green_layout, rq.raw);
          res.blue  = unpack_channel(blue_layout, rq.raw);
          res.last  = 1'b1;
          results_q.push_back(res);
        end
        default: ;  // unused request: no result
      endcase
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Match a result against the oldest prediction
    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (results_q.size() == 0) begin
        $error("unexpected result: offset %0h pixel %0h", got.byte_offset, got.packed_pixel);
        errors++;
        return;
      end
      want = results_q.pop_front();
      compare_field("out_write_enable", want.write_enable, got.write_enable);
      compare_field("out_byte_offset", want.byte_offset, got.byte_offset);
      compare_field("out_packed_pixel", want.packed_pixel, got.packed_pixel);
      compare_field("out_red", want.red, got.red);
      compare_field("out_green", want.green, got.green);
      compare_field("out_blue", want.blue, got.blue);
      compare_field("out_last", want.last, got.last);
    endfunction
  endclass

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 start            = 1'b0;
  logic                 busy;
  logic [1:0]           in_req_type      = '0;
  logic [POS_W-1:0]     in_pos_x         = '0;
  logic [POS_W-1:0]     in_pos_y         = '0;
  logic [63:0]          in_glyph_bits    = '0;
  logic [COL_W-1:0]     in_fg_red        = '0;
  logic [COL_W-1:0]     in_fg_green      = '0;
  logic [COL_W-1:0]     in_fg_blue       = '0;
  logic [COL_W-1:0]     in_bg_red        = '0;
  logic [COL_W-1:0]     in_bg_green      = '0;
  logic [COL_W-1:0]     in_bg_blue       = '0;
  logic [PIX_W-1:0]     in_raw_pixel     = '0;
  logic                 cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  logic                 out_strobe;
  logic                 out_write_enable;
  logic [OFS_W-1:0]     out_byte_offset;
  logic [PIX_W-1:0]     out_packed_pixel;
  logic [COL_W-1:0]     out_red;
  logic [COL_W-1:0]     out_green;
  logic [COL_W-1:0]     out_blue;
  logic                 out_last;

  pixel_scoreboard sb = new();
  int unsigned     cycle_count = 0;

  glyph_to_framebuffer_writer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_glyph_bits    (in_glyph_bits),
    .in_fg_red        (in_fg_red),
    .in_fg_green      (in_fg_green),
    .in_fg_blue       (in_fg_blue),
    .in_bg_red        (in_bg_red),
    .in_bg_green      (in_bg_green),
    .in_bg_blue       (in_bg_blue),
    .in_raw_pixel     (in_raw_pixel),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_strobe       (out_strobe),
    .out_write_enable (out_write_enable),
    .out_byte_offset  (out_byte_offset),
    .out_packed_pixel (out_packed_pixel),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last         (out_last)
  );

  // Clock: period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note accepted items and check strobed results
  always @(posedge clk) begin
    pixel_request_t rq;
    pixel_result_t  got;
    if (rst_n) begin
      if (start && !busy) begin
        rq.kind     = req_t'(in_req_type);
        rq.x        = in_pos_x;
        rq.y        = in_pos_y;
        rq.glyph    = in_glyph_bits;
        rq.fg_red   = in_fg_red;
        rq.fg_green = in_fg_green;
        rq.fg_blue  = in_fg_blue;
        rq.bg_red   = in_bg_red;
        rq.bg_green = in_bg_green;
        rq.bg_blue  = in_bg_blue;
        rq.raw      = in_raw_pixel;
        sb.note_request(rq);
      end
      if (out_strobe) begin
        got.write_enable = out_write_enable;
        got.byte_offset  = out_byte_offset;
        got.packed_pixel = out_packed_pixel;
        got.red          = out_red;
        got.green        = out_green;
        got.blue         = out_blue;
        got.last         = out_last;
        sb.check_result(got);
      end
    end
  end

  function automatic pixel_request_t request_of(req_t kind, bit [11:0] x, bit [11:0] y,
                                                bit [63:0] glyph, bit [23:0] fg,
                                                bit [23:0] bg, bit [31:0] raw);
    pixel_request_t rq;
    rq.kind  = kind;
    rq.x     = x;
    rq.y     = y;
    rq.glyph = glyph;
    {rq.fg_red, rq.fg_green, rq.fg_blue} = fg;
    {rq.bg_red, rq.bg_green, rq.bg_blue} = bg;
    rq.raw   = raw;
    return rq;
  endfunction

  // Colour level with the extremes favoured
  function automatic bit [7:0] random_level();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Coordinate within or just past the frame, or anywhere in the field
  function automatic bit [11:0] random_coord(int unsigned span);
    if ($urandom_range(0, 3) == 0) return 12'($urandom);
    if (span > 4095) span = 4095;
    return 12'($urandom_range(0, span));
  endfunction

  function automatic bit [12:0] random_dim();
    case ($urandom_range(0, 7))
      0:       return 13'd1;
      1:       return 13'd4096;
      2:       return 13'($urandom);
      default: return 13'($urandom_range(8, 700));
    endcase
  endfunction

  function automatic frame_setup_t random_setup();
    frame_setup_t s;
    s.width        = random_dim();
    s.height       = random_dim();
    s.bpp          = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    s.red_layout   = 9'($urandom);
    s.green_layout = 9'($urandom);
    s.blue_layout  = 9'($urandom);
    return s;
  endfunction

  function automatic pixel_request_t random_request(frame_setup_t s);
    pixel_request_t rq;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      rq.kind = REQ_WRITE;
    else if (pick < 58) rq.kind = REQ_GLYPH;
    else if (pick < 92) rq.kind = REQ_DECODE;
    else                rq.kind = REQ_NONE;
    // Glyph positions are cells, so scale the frame down
    if (rq.kind == REQ_GLYPH) begin
      rq.x = random_coord(s.width / GLYPH_SIZE + 1);
      rq.y = random_coord(s.height / GLYPH_SIZE + 1);
    end else begin
      rq.x = random_coord(s.width + 1);
      rq.y = random_coord(s.height + 1);
    end
    rq.glyph    = {$urandom, $urandom};
    rq.fg_red   = random_level();
    rq.fg_green = random_level();
    rq.fg_blue  = random_level();
    rq.bg_red   = random_level();
    rq.bg_green = random_level();
    rq.bg_blue  = random_level();
    rq.raw      = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
    return rq;
  endfunction

  // Present an item and hold it until the block takes it
  task automatic send_request(pixel_request_t rq);
    start         <= 1'b1;
    in_req_type   <= rq.kind;
    in_pos_x      <= rq.x;
    in_pos_y      <= rq.y;
    in_glyph_bits <= rq.glyph;
    in_fg_red     <= rq.fg_red;
    in_fg_green   <= rq.fg_green;
    in_fg_blue    <= rq.fg_blue;
    in_bg_red     <= rq.bg_red;
    in_bg_green   <= rq.bg_green;
    in_bg_blue    <= rq.bg_blue;
    in_raw_pixel  <= rq.raw;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_input(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait for every predicted result, then let the pipe settle so a stray result is seen
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all six registers while the block is idle
  task automatic apply_setup(frame_setup_t s);
    bit [CFG_DATA_W-1:0] value [6];
    cfg_idx_t            order [6];
    drain();
    order = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_BYTES_PP,
              CFG_RED_LAYOUT, CFG_GREEN_LAYOUT, CFG_BLUE_LAYOUT};
    // Spare upper data bits carry noise that the narrow registers drop
    value[0] = s.width;
    value[1] = s.height;
    value[2] = {10'($urandom), s.bpp};
    value[3] = {4'($urandom), s.red_layout};
    value[4] = {4'($urandom), s.green_layout};
    value[5] = {4'($urandom), s.blue_layout};
    for (int k = 0; k < 6; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= value[k];
      sb.write_reg(order[k], value[k]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** glyph_to_framebuffer_writer: FAILED **");
    $finish;
  end

  initial begin
    frame_setup_t setup;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry: corners, frame edges, field extremes
    send_request(request_of(REQ_WRITE, 12'd0, 12'd0, '0, 24'h000000, 24'h0, 32'h0));
    send_request(request_of(REQ_WRITE, 12'd639, 12'd479, '0, 24'hFFFFFF, 24'h0, 32'h0));
    send_request(request_of(REQ_WRITE, 12'd640, 12'd0, '0, 24'h123456, 24'h0, 32'h0));
    send_request(request_of(REQ_WRITE, 12'd0, 12'd480, '0, 24'h80FF01, 24'h0, 32'h0));
    send_request(request_of(REQ_WRITE, 12'hFFF, 12'hFFF, '0, 24'h7F807F, 24'h0, 32'h0));
    send_request(request_of(REQ_GLYPH, 12'd0, 12'd0, 64'h0123_4567_89AB_CDEF,
                            24'hFF8000, 24'h0010FF, 32'h0));
    send_request(request_of(REQ_GLYPH, 12'd79, 12'd59, 64'hFFFF_FFFF_FFFF_FFFF,
                            24'hFFFFFF, 24'h000000, 32'h0));
    send_request(request_of(REQ_GLYPH, 12'hFFF, 12'hFFF, 64'h0,
                            24'hFFFFFF, 24'hA5C35A, 32'h0));
    send_request(request_of(REQ_DECODE, 12'd0, 12'd0, '0, 24'h0, 24'h0, 32'h0000_0000));
    send_request(request_of(REQ_DECODE, 12'hFFF, 12'hFFF, '0, 24'h0, 24'h0, 32'hFFFF_FFFF));
    send_request(request_of(REQ_DECODE, 12'd0, 12'd0, '0, 24'h0, 24'h0, 32'h5A3C_E718));
    send_request(request_of(REQ_NONE, 12'd1, 12'd1, '1, 24'hFFFFFF, 24'hFFFFFF, 32'h1));
    send_request(request_of(REQ_WRITE, 12'd1, 12'd2, '0, 24'h010203, 24'h0, 32'h0));

    // Largest legal frame, one byte per pixel, tiny, clipped and overlapping channels
    setup = '{13'd4096, 13'd4096, 3'd1, {5'd31, 4'd0}, {5'd20, 4'd15}, {5'd0, 4'd15}};
    apply_setup(setup);
    send_request(request_of(REQ_WRITE, 12'hFFF, 12'hFFF, '0, 24'hFFFFFF, 24'h0, 32'h0));
    send_request(request_of(REQ_GLYPH, 12'd511, 12'd511, 64'hF0F0_0F0F_AAAA_5555,
                            24'h80C0FF, 24'h01FE7F, 32'h0));
    send_request(request_of(REQ_DECODE, 12'd0, 12'd0, '0, 24'h0, 24'h0, 32'hFFFF_FFFF));
    send_request(request_of(REQ_DECODE, 12'd0, 12'd0, '0, 24'h0, 24'h0, 32'h8765_4321));

    // Oversized frame: cells beyond the dimension cap and a wrapping offset
    setup = '{13'h1FFF, 13'h1FFF, 3'd7, 9'h1FF, 9'h0F3, 9'h0A8};
    apply_setup(setup);
    send_request(request_of(REQ_GLYPH, 12'hFFF, 12'd0, 64'h8000_0000_0000_0001,
                            24'hFFFFFF, 24'h000000, 32'h0));
    send_request(request_of(REQ_WRITE, 12'hFFF, 12'hFFF, '0, 24'hFF00FF, 24'h0, 32'h0));

    // Zero-sized frame and zero multiplier
    setup = '{13'd0, 13'd0, 3'd0, 9'd7, 9'd135, 9'd391};
    apply_setup(setup);
    send_request(request_of(REQ_WRITE, 12'd0, 12'd0, '0, 24'hFFFFFF, 24'h0, 32'h0));
    send_request(request_of(REQ_GLYPH, 12'd0, 12'd0, 64'h3C42_8181_8181_423C,
                            24'hFFFFFF, 24'h000000, 32'h0));

    // Random phases; the last one streams without gaps
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      setup = random_setup();
      apply_setup(setup);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase < RANDOM_PHASES - 1 && $urandom_range(0, 3) == 0)
          pause_input($urandom_range(1, 9));
        send_request(random_request(setup));
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("** glyph_to_framebuffer_writer: PASSED **");
    end else begin
      $display("** glyph_to_framebuffer_writer: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/gfw_pkg.sv
rtl/core/gfw_front.sv
rtl/core/gfw_queue.sv
rtl/core/gfw_seq.sv
rtl/core/gfw_pix.sv
rtl/core/glyph_to_framebuffer_writer.sv
tb/glyph_to_framebuffer_writer_tb.sv
